### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define SLA_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked at every edge, reset included.
`define SLA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### sv/sla_pkg.sv
// ---------------------------------------------------------------------------
// sla_pkg
// Shared types, codes and defaults for the semi-Lagrangian advection cell.
// ---------------------------------------------------------------------------
`default_nettype none

package sla_pkg;

  localparam int MAX_COLS_DEF   = 64;
  localparam int MAX_ROWS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int WEIGHT_BITS = 18;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;

  localparam weight_t W_ZERO     = 18'sd0;
  localparam weight_t W_HALF     = 18'sd32768;
  localparam weight_t W_NEG_HALF = -18'sd32768;
  localparam weight_t W_ONE      = 18'sd65536;

  // item kinds
  localparam logic [1:0] MODE_LOAD_X  = 2'd0;
  localparam logic [1:0] MODE_LOAD_Y  = 2'd1;
  localparam logic [1:0] MODE_LOAD_F  = 2'd2;
  localparam logic [1:0] MODE_COMPUTE = 2'd3;

  // register indexes
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STEP_RATIO  = 2'd2;
  localparam logic [1:0] REG_FIELD_OFS   = 2'd3;

  // field offset codes
  localparam logic [1:0] OFS_CENTER = 2'd0;
  localparam logic [1:0] OFS_XFACE  = 2'd1;
  localparam logic [1:0] OFS_YFACE  = 2'd2;

  localparam logic [6:0]  GRID_WIDTH_RST  = 7'd64;
  localparam logic [6:0]  GRID_HEIGHT_RST = 7'd64;
  localparam logic [31:0] STEP_RATIO_RST  = 32'd1677722;
  localparam logic [1:0]  FIELD_OFS_RST   = OFS_CENTER;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] sample;
  } item_t;

endpackage

`default_nettype wire

### sv/semi_lagrangian_advect_cell.sv
// ---------------------------------------------------------------------------
// semi_lagrangian_advect_cell
// Throughput: one transaction per cycle, loads and computes alike, except while
// a compute result at the pipeline end waits on a stalled output; the rate
// is set by the 16-stage pipeline with four banked copies of each grid.
// Reset (rst_n low, synchronous): pipeline and output emptied, registers
// back to defaults; grid stores are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module semi_lagrangian_advect_cell #(
  parameter int MAX_COLS   = sla_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = sla_pkg::MAX_ROWS_DEF,
  parameter int VALUE_BITS = sla_pkg::VALUE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // col[5:0], row[11:6], sample[43:12]
  input  wire logic [1:0]  in_tuser,   // mode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,  // out_col[5:0], out_row[11:6], advected[43:12]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int COL_BITS  = $clog2(MAX_COLS);
  localparam int ROW_BITS  = $clog2(MAX_ROWS);
  localparam int CELLS     = MAX_COLS * MAX_ROWS;
  localparam int ADDR_BITS = $clog2(CELLS);
  localparam int RES_BITS  = VALUE_BITS + 8;
  localparam int MW        = VALUE_BITS + 11;
  localparam int DW        = (VALUE_BITS + 12 > COL_BITS + 18) ?
                             VALUE_BITS + 12 : COL_BITS + 18;
  localparam int DWY       = (VALUE_BITS + 12 > ROW_BITS + 18) ?
                             VALUE_BITS + 12 : ROW_BITS + 18;
  localparam int OUT_BITS  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int STAGES    = 16;

  function automatic logic [ADDR_BITS-1:0] cell_addr(input int c, input int r);
    return ADDR_BITS'(r * MAX_COLS + c);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] sat_val(
    input logic signed [RES_BITS-1:0] r);
    logic [RES_BITS-VALUE_BITS:0] hi_bits;
    hi_bits = r[RES_BITS-1:VALUE_BITS-1];
    if (&hi_bits || ~|hi_bits) return r[VALUE_BITS-1:0];
    else if (r[RES_BITS-1]) return {1'b1, {(VALUE_BITS-1){1'b0}}};
    else return {1'b0, {(VALUE_BITS-1){1'b1}}};
  endfunction

  function automatic logic signed [OUT_BITS-1:0] sat_out(
    input logic signed [RES_BITS-1:0] r);
    logic [RES_BITS-OUT_BITS:0] hi_bits;
    hi_bits = r[RES_BITS-1:OUT_BITS-1];
    if (&hi_bits || ~|hi_bits) return r[OUT_BITS-1:0];
    else if (r[RES_BITS-1]) return {1'b1, {(OUT_BITS-1){1'b0}}};
    else return {1'b0, {(OUT_BITS-1){1'b1}}};
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] sat_load(
    input logic signed [31:0] s);
    logic signed [48:0]     se;
    logic [49-VALUE_BITS:0] hi_bits;
    se      = 49'(s);
    hi_bits = se[48:VALUE_BITS-1];
    if (&hi_bits || ~|hi_bits) return se[VALUE_BITS-1:0];
    else if (se[48]) return {1'b1, {(VALUE_BITS-1){1'b0}}};
    else return {1'b0, {(VALUE_BITS-1){1'b1}}};
  endfunction

  // configuration
  logic [6:0]  grid_width_r, grid_height_r;
  logic [31:0] step_ratio_r;
  logic [1:0]  field_ofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= sla_pkg::GRID_WIDTH_RST;
      grid_height_r <= sla_pkg::GRID_HEIGHT_RST;
      step_ratio_r  <= sla_pkg::STEP_RATIO_RST;
      field_ofs_r   <= sla_pkg::FIELD_OFS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sla_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[6:0];
        sla_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_wdata[6:0];
        sla_pkg::REG_STEP_RATIO:  step_ratio_r  <= cfg_wdata;
        sla_pkg::REG_FIELD_OFS:   field_ofs_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic [COL_BITS-1:0] wm1, wm2;
  logic [ROW_BITS-1:0] hm1, hm2;
  logic                hx, hy;

  always_comb begin
    if (int'(grid_width_r) < 2) wm1 = COL_BITS'(1);
    else if (int'(grid_width_r) > MAX_COLS) wm1 = COL_BITS'(MAX_COLS - 1);
    else wm1 = COL_BITS'(int'(grid_width_r) - 1);
    if (int'(grid_height_r) < 2) hm1 = ROW_BITS'(1);
    else if (int'(grid_height_r) > MAX_ROWS) hm1 = ROW_BITS'(MAX_ROWS - 1);
    else hm1 = ROW_BITS'(int'(grid_height_r) - 1);
    wm2 = wm1 - COL_BITS'(1);
    hm2 = hm1 - ROW_BITS'(1);
  end

  assign hx = (field_ofs_r == sla_pkg::OFS_XFACE);
  assign hy = (field_ofs_r == sla_pkg::OFS_YFACE);

  // pipeline control
  sla_pkg::item_t      itm_r [STAGES];
  logic [STAGES-1:0]   vld_r;
  logic                out_tvalid_r;
  logic [47:0]         out_tdata_r;
  logic                out_ld, adv, last_res;
  sla_pkg::item_t      itm_in;

  assign last_res  = vld_r[STAGES-1] && (itm_r[STAGES-1].mode == sla_pkg::MODE_COMPUTE);
  assign out_ld    = !out_tvalid_r || out_tready;
  assign adv       = out_ld || !last_res;
  assign in_tready = adv;

  assign itm_in.mode   = in_tuser[1:0];
  assign itm_in.col    = in_tdata[5:0];
  assign itm_in.row    = in_tdata[11:6];
  assign itm_in.sample = in_tdata[43:12];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[STAGES-2:0], in_tvalid};
      end
      if (out_ld) begin
        out_tvalid_r <= last_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itm_r[0] <= itm_in;
      for (int k = 1; k < STAGES; k++) begin
        itm_r[k] <= itm_r[k-1];
      end
    end
  end

  // stage 0: clamp cell, velocity corners and weights
  logic [COL_BITS-1:0] ci_c, ux1, ux2, vx1, vx2;
  logic [ROW_BITS-1:0] cj_c, uy1, uy2, vy1, vy2;
  sla_pkg::weight_t    utx, uty, vtx, vty;

  always_comb begin
    ci_c = (int'(itm_r[0].col) > int'(wm1)) ? wm1 : COL_BITS'(itm_r[0].col);
    cj_c = (int'(itm_r[0].row) > int'(hm1)) ? hm1 : ROW_BITS'(itm_r[0].row);

    // x velocity lives on x faces
    if (hx) begin
      ux1 = ci_c;
      utx = sla_pkg::W_ZERO;
    end else if (ci_c == '0) begin
      ux1 = '0;
      utx = sla_pkg::W_NEG_HALF;
    end else begin
      ux1 = ci_c - COL_BITS'(1);
      utx = sla_pkg::W_HALF;
    end
    uy1 = (cj_c > hm2) ? hm2 : cj_c;
    uty = ((cj_c != uy1) ? sla_pkg::W_ONE : sla_pkg::W_ZERO) +
          (hy ? sla_pkg::W_HALF : sla_pkg::W_ZERO);

    // y velocity lives on y faces
    vx1 = (ci_c > wm2) ? wm2 : ci_c;
    vtx = ((ci_c != vx1) ? sla_pkg::W_ONE : sla_pkg::W_ZERO) +
          (hx ? sla_pkg::W_HALF : sla_pkg::W_ZERO);
    if (hy) begin
      vy1 = cj_c;
      vty = sla_pkg::W_ZERO;
    end else if (cj_c == '0) begin
      vy1 = '0;
      vty = sla_pkg::W_NEG_HALF;
    end else begin
      vy1 = cj_c - ROW_BITS'(1);
      vty = sla_pkg::W_HALF;
    end

    ux2 = (ux1 == wm1) ? wm1 : ux1 + COL_BITS'(1);
    uy2 = (uy1 == hm1) ? hm1 : uy1 + ROW_BITS'(1);
    vx2 = (vx1 == wm1) ? wm1 : vx1 + COL_BITS'(1);
    vy2 = (vy1 == hm1) ? hm1 : vy1 + ROW_BITS'(1);
  end

  logic                  ld_ok0, ld_ok10;
  logic [ADDR_BITS-1:0]  wa0, wa10;
  logic [VALUE_BITS-1:0] ld_val0, ld_val10;

  assign ld_ok0   = (int'(itm_r[0].col) < MAX_COLS) && (int'(itm_r[0].row) < MAX_ROWS);
  assign ld_ok10  = (int'(itm_r[10].col) < MAX_COLS) && (int'(itm_r[10].row) < MAX_ROWS);
  assign wa0      = cell_addr(int'(itm_r[0].col), int'(itm_r[0].row));
  assign wa10     = cell_addr(int'(itm_r[10].col), int'(itm_r[10].row));
  assign ld_val0  = sat_load(itm_r[0].sample);
  assign ld_val10 = sat_load(itm_r[10].sample);

  logic [ADDR_BITS-1:0]  xr_addr [4], yr_addr [4], fr_addr [4];
  logic [VALUE_BITS-1:0] xr_data [4], yr_data [4], fr_data [4];
  logic                  xwe, ywe, fwe;

  assign xr_addr[0] = cell_addr(int'(ux1), int'(uy1));
  assign xr_addr[1] = cell_addr(int'(ux2), int'(uy1));
  assign xr_addr[2] = cell_addr(int'(ux1), int'(uy2));
  assign xr_addr[3] = cell_addr(int'(ux2), int'(uy2));
  assign yr_addr[0] = cell_addr(int'(vx1), int'(vy1));
  assign yr_addr[1] = cell_addr(int'(vx2), int'(vy1));
  assign yr_addr[2] = cell_addr(int'(vx1), int'(vy2));
  assign yr_addr[3] = cell_addr(int'(vx2), int'(vy2));

  assign xwe = adv && vld_r[0] && ld_ok0 && (itm_r[0].mode == sla_pkg::MODE_LOAD_X);
  assign ywe = adv && vld_r[0] && ld_ok0 && (itm_r[0].mode == sla_pkg::MODE_LOAD_Y);
  assign fwe = adv && vld_r[10] && ld_ok10 && (itm_r[10].mode == sla_pkg::MODE_LOAD_F);

  sla_bank #(.DEPTH(CELLS), .DATA_BITS(VALUE_BITS), .PORTS(4)) u_xvel (
    .clk(clk), .en(adv), .we(xwe), .wr_addr(wa0), .wr_data(ld_val0),
    .rd_addr(xr_addr), .rd_data(xr_data)
  );

  sla_bank #(.DEPTH(CELLS), .DATA_BITS(VALUE_BITS), .PORTS(4)) u_yvel (
    .clk(clk), .en(adv), .we(ywe), .wr_addr(wa0), .wr_data(ld_val0),
    .rd_addr(yr_addr), .rd_data(yr_data)
  );

  // stage 1: velocity weights beside the read data
  sla_pkg::weight_t    utx_r, uty_r, vtx_r, vty_r;
  logic [COL_BITS-1:0] ci_r [1:8];
  logic [ROW_BITS-1:0] cj_r [1:8];

  always_ff @(posedge clk) begin
    if (adv) begin
      utx_r   <= utx;
      uty_r   <= uty;
      vtx_r   <= vtx;
      vty_r   <= vty;
      ci_r[1] <= ci_c;
      cj_r[1] <= cj_c;
      for (int k = 2; k <= 8; k++) begin
        ci_r[k] <= ci_r[k-1];
        cj_r[k] <= cj_r[k-1];
      end
    end
  end

  logic signed [RES_BITS-1:0] u_res, v_res, f_res;

  sla_bilerp #(.VALUE_BITS(VALUE_BITS)) u_blend_u (
    .clk(clk), .en(adv), .tx(utx_r), .ty(uty_r),
    .q11(xr_data[0]), .q21(xr_data[1]), .q12(xr_data[2]), .q22(xr_data[3]),
    .result(u_res)
  );

  sla_bilerp #(.VALUE_BITS(VALUE_BITS)) u_blend_v (
    .clk(clk), .en(adv), .tx(vtx_r), .ty(vty_r),
    .q11(yr_data[0]), .q21(yr_data[1]), .q12(yr_data[2]), .q22(yr_data[3]),
    .result(v_res)
  );

  // stage 6: saturated velocities
  logic signed [VALUE_BITS-1:0] u_r, v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r <= sat_val(u_res);
      v_r <= sat_val(v_res);
    end
  end

  logic signed [MW-1:0] mx, my;

  sla_stepmul #(.VALUE_BITS(VALUE_BITS)) u_step_x (
    .clk(clk), .en(adv), .step(step_ratio_r), .vel(u_r), .disp(mx)
  );

  sla_stepmul #(.VALUE_BITS(VALUE_BITS)) u_step_y (
    .clk(clk), .en(adv), .step(step_ratio_r), .vel(v_r), .disp(my)
  );

  // stage 9: departure point, clamped to the grid
  logic signed [DW-1:0]     xq, xd, xlim;
  logic signed [DWY-1:0]    yq, yd, ylim;
  logic [COL_BITS+15:0]     xp_r;
  logic [ROW_BITS+15:0]     yp_r;

  always_comb begin
    xq   = $signed(DW'({ci_r[8], hx, 15'h0000}));
    yq   = $signed(DWY'({cj_r[8], hy, 15'h0000}));
    xd   = xq - DW'(mx);
    yd   = yq - DWY'(my);
    xlim = $signed(DW'({wm1, 16'h0000}));
    ylim = $signed(DWY'({hm1, 16'h0000}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (xd[DW-1]) xp_r <= '0;
      else if (xd > xlim) xp_r <= {wm1, 16'h0000};
      else xp_r <= xd[COL_BITS+15:0];
      if (yd[DWY-1]) yp_r <= '0;
      else if (yd > ylim) yp_r <= {hm1, 16'h0000};
      else yp_r <= yd[ROW_BITS+15:0];
    end
  end

  // stage 10: field corners and weights
  logic signed [COL_BITS+16:0] fxd;
  logic signed [ROW_BITS+16:0] fyd;
  logic [COL_BITS-1:0]         fx1_c;
  logic [ROW_BITS-1:0]         fy1_c;
  sla_pkg::weight_t            ftx_c, fty_c;

  always_comb begin
    fxd = $signed({1'b0, xp_r}) - $signed({{(COL_BITS+1){1'b0}}, hx, 15'h0000});
    fyd = $signed({1'b0, yp_r}) - $signed({{(ROW_BITS+1){1'b0}}, hy, 15'h0000});
    if (fxd[COL_BITS+16]) begin
      fx1_c = '0;
      ftx_c = sla_pkg::WEIGHT_BITS'(fxd);
    end else begin
      fx1_c = fxd[COL_BITS+15:16];
      ftx_c = $signed({2'b00, fxd[15:0]});
    end
    if (fyd[ROW_BITS+16]) begin
      fy1_c = '0;
      fty_c = sla_pkg::WEIGHT_BITS'(fyd);
    end else begin
      fy1_c = fyd[ROW_BITS+15:16];
      fty_c = $signed({2'b00, fyd[15:0]});
    end
  end

  logic [COL_BITS-1:0] fx1_r, fx2_r;
  logic [ROW_BITS-1:0] fy1_r, fy2_r;
  sla_pkg::weight_t    ftx_r, fty_r, ftx2_r, fty2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      fx1_r  <= fx1_c;
      fy1_r  <= fy1_c;
      fx2_r  <= (fx1_c == wm1) ? wm1 : fx1_c + COL_BITS'(1);
      fy2_r  <= (fy1_c == hm1) ? hm1 : fy1_c + ROW_BITS'(1);
      ftx_r  <= ftx_c;
      fty_r  <= fty_c;
      ftx2_r <= ftx_r;
      fty2_r <= fty_r;
    end
  end

  // field loads are written here so earlier computes still see the old value
  assign fr_addr[0] = cell_addr(int'(fx1_r), int'(fy1_r));
  assign fr_addr[1] = cell_addr(int'(fx2_r), int'(fy1_r));
  assign fr_addr[2] = cell_addr(int'(fx1_r), int'(fy2_r));
  assign fr_addr[3] = cell_addr(int'(fx2_r), int'(fy2_r));

  sla_bank #(.DEPTH(CELLS), .DATA_BITS(VALUE_BITS), .PORTS(4)) u_field (
    .clk(clk), .en(adv), .we(fwe), .wr_addr(wa10), .wr_data(ld_val10),
    .rd_addr(fr_addr), .rd_data(fr_data)
  );

  sla_bilerp #(.VALUE_BITS(VALUE_BITS)) u_blend_f (
    .clk(clk), .en(adv), .tx(ftx2_r), .ty(fty2_r),
    .q11(fr_data[0]), .q21(fr_data[1]), .q12(fr_data[2]), .q22(fr_data[3]),
    .result(f_res)
  );

  // output register
  logic signed [OUT_BITS-1:0] f_sat;
  assign f_sat = sat_out(f_res);

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_tdata_r <= {4'h0, 32'(f_sat), itm_r[STAGES-1].row, itm_r[STAGES-1].col};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

### sv/sla_bank.sv
// ---------------------------------------------------------------------------
// sla_bank
// One grid store, copied once per read port; one shared write port.
// ---------------------------------------------------------------------------
`default_nettype none

module sla_bank #(
  parameter int DEPTH     = sla_pkg::MAX_COLS_DEF * sla_pkg::MAX_ROWS_DEF,
  parameter int DATA_BITS = sla_pkg::VALUE_BITS_DEF,
  parameter int PORTS     = 4,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0] wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr [PORTS],
  output logic      [DATA_BITS-1:0] rd_data [PORTS]
);

  for (genvar p = 0; p < PORTS; p++) begin : g_copy
    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wr_addr] <= wr_data;
      end
      if (en) begin
        rd_r <= mem[rd_addr[p]];
      end
    end

    assign rd_data[p] = rd_r;
  end

endmodule

`default_nettype wire

### sv/sla_bilerp.sv
// ---------------------------------------------------------------------------
// sla_bilerp
// Four-stage bilinear blend of four corners, products rounded half up.
// ---------------------------------------------------------------------------
`default_nettype none

module sla_bilerp #(
  parameter int VALUE_BITS = sla_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire sla_pkg::weight_t             tx,
  input  wire sla_pkg::weight_t             ty,
  input  wire logic signed [VALUE_BITS-1:0] q11,
  input  wire logic signed [VALUE_BITS-1:0] q21,
  input  wire logic signed [VALUE_BITS-1:0] q12,
  input  wire logic signed [VALUE_BITS-1:0] q22,
  output logic signed [VALUE_BITS+7:0]      result
);

  localparam int PB  = VALUE_BITS + 1 + sla_pkg::WEIGHT_BITS;
  localparam int AB  = VALUE_BITS + 5;
  localparam int P3B = AB + 1 + sla_pkg::WEIGHT_BITS;
  localparam int RB  = VALUE_BITS + 8;

  localparam logic signed [PB-1:0]  RND1 = PB'(32768);
  localparam logic signed [P3B-1:0] RND3 = P3B'(32768);

  logic signed [PB-1:0]         p1_r, p2_r;
  logic signed [VALUE_BITS-1:0] q11_r, q12_r;
  sla_pkg::weight_t             ty1_r, ty2_r;
  logic signed [AB-1:0]         a_r, b_r, a3_r;
  logic signed [P3B-1:0]        p3_r;
  logic signed [RB-1:0]         res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= tx * (q21 - q11);
      p2_r  <= tx * (q22 - q12);
      q11_r <= q11;
      q12_r <= q12;
      ty1_r <= ty;

      a_r   <= AB'(q11_r) + AB'((p1_r + RND1) >>> 16);
      b_r   <= AB'(q12_r) + AB'((p2_r + RND1) >>> 16);
      ty2_r <= ty1_r;

      p3_r  <= ty2_r * (b_r - a_r);
      a3_r  <= a_r;

      res_r <= RB'(a3_r) + RB'((p3_r + RND3) >>> 16);
    end
  end

  assign result = res_r;

endmodule

`default_nettype wire

### sv/sla_stepmul.sv
// ---------------------------------------------------------------------------
// sla_stepmul
// Two-stage product of the Q8.24 step ratio and a Q16.16 velocity,
// rounded half up to Q16.16.
// ---------------------------------------------------------------------------
`default_nettype none

module sla_stepmul #(
  parameter int VALUE_BITS = sla_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [31:0]                  step,
  input  wire logic signed [VALUE_BITS-1:0] vel,
  output logic signed [VALUE_BITS+10:0]     disp
);

  localparam int VE = VALUE_BITS + 1;
  localparam int HB = VE - 16;
  localparam int PH = 33 + HB;
  localparam int SW = PH + 17;
  localparam int MW = VALUE_BITS + 11;

  localparam logic signed [SW-1:0] RND = SW'(1 << 23);

  logic signed [VE-1:0] ve;
  logic [47:0]          pl_r;
  logic signed [PH-1:0] ph_r;
  logic signed [SW-1:0] sum;
  logic signed [MW-1:0] disp_r;

  assign ve = VE'(vel);

  always_comb begin
    sum = (SW'(ph_r) <<< 16) + $signed(SW'(pl_r)) + RND;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r   <= step * ve[15:0];
      ph_r   <= $signed({1'b0, step}) * $signed(ve[VE-1:16]);
      disp_r <= MW'(sum >>> 24);
    end
  end

  assign disp = disp_r;

endmodule

`default_nettype wire

### sv/sla_checker.sv
// ---------------------------------------------------------------------------
// sla_checker
// Port-level checks for the advection cell, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sla_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  `SLA_ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result dropped or changed while stalled")

  `SLA_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "result present right after reset")

  `SLA_ASSERT_RST(a_ready_free, clk, rst_n, (!out_tvalid || out_tready) |-> in_tready, "input stalled with a free output")

  `SLA_ASSERT_RST(a_pad_zero, clk, rst_n, out_tvalid |-> (out_tdata[47:44] == 4'h0), "nonzero pad bits in result")

endmodule

bind semi_lagrangian_advect_cell sla_checker u_sla_checker (.*);

`default_nettype wire

### verif/tb_semi_lagrangian_advect_cell.sv
// ---------------------------------------------------------------------------
// tb_semi_lagrangian_advect_cell
// Self-checking bench for the semi-Lagrangian advection cell. It loads the
// velocity and field grids, issues compute transactions, predicts each
// advected value with its own Q16.16 model of the block and compares every
// result in order. Before a compute, any grid entry it would read that was
// never written is loaded first. Both sides stall at random, and the
// registers are swept between phases.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_semi_lagrangian_advect_cell;

  localparam int  CELLS     = 4096;
  localparam int  WD_LIMIT  = 5000;
  localparam int  DRAIN     = 40;
  localparam int  N_ITEMS   = 1900;

  typedef struct {
    logic [5:0]         col;
    logic [5:0]         row;
    logic signed [31:0] value;
  } advect_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  // model state
  longint      grid_val [3][CELLS];
  bit          grid_set [3][CELLS];
  logic [6:0]  width_reg;
  logic [6:0]  height_reg;
  logic [31:0] ratio_reg;
  logic [1:0]  ofs_reg;

  advect_t     pending_q[$];
  int          mismatches;
  int          items_sent;
  int          idle_cycles;
  bit          quiet;

  semi_lagrangian_advect_cell u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------- fixed-point helpers ----------------
  function automatic longint mul_q16(longint t, longint d);
    longint dh;
    longint dl;
    dh = d >>> 16;
    dl = d - (dh <<< 16);
    return t * dh + ((t * dl + 64'sd32768) >>> 16);
  endfunction

  function automatic longint mul_step(longint s, longint v);
    longint sh;
    longint sl;
    longint vh;
    longint vl;
    sh = s >>> 24;
    sl = s & 64'hFFFFFF;
    vh = v >>> 24;
    vl = v - (vh <<< 24);
    return sh * v + sl * vh + ((sl * vl + (64'sd1 <<< 23)) >>> 24);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint corner(longint p, longint off, longint top);
    longint d;
    longint k;
    d = p - off;
    k = (d < 0) ? 0 : (d >>> 16);
    return (k > top) ? top : k;
  endfunction

  function automatic longint fetch(int g, longint x, longint y, inout int miss);
    int idx;
    idx = int'(y) * 64 + int'(x);
    if (!grid_set[g][idx]) begin
      if (miss < 0) miss = g * CELLS + idx;
      return 0;
    end
    return grid_val[g][idx];
  endfunction

  function automatic longint bilerp(int g, longint px, longint py, longint x1, longint y1,
                                    longint ox, longint oy, longint w, longint h,
                                    inout int miss);
    longint x2;
    longint y2;
    longint tx;
    longint ty;
    longint q11;
    longint q21;
    longint q12;
    longint q22;
    longint a;
    longint b;
    x2 = (x1 + 1 > w - 1) ? w - 1 : x1 + 1;
    y2 = (y1 + 1 > h - 1) ? h - 1 : y1 + 1;
    tx = px - ((x1 <<< 16) + ox);
    ty = py - ((y1 <<< 16) + oy);
    q11 = fetch(g, x1, y1, miss);
    q21 = fetch(g, x2, y1, miss);
    q12 = fetch(g, x1, y2, miss);
    q22 = fetch(g, x2, y2, miss);
    a = q11 + mul_q16(tx, q21 - q11);
    b = q12 + mul_q16(tx, q22 - q12);
    return a + mul_q16(ty, b - a);
  endfunction

  // Returns the first unwritten entry the cell would read, or -1.
  function automatic int advect_cell(logic [5:0] col, logic [5:0] row, output longint res);
    longint w;
    longint h;
    longint i;
    longint j;
    longint xo;
    longint yo;
    longint x;
    longint y;
    longint u;
    longint v;
    longint xp;
    longint yp;
    int     miss;
    miss = -1;
    w = (width_reg < 2) ? 2 : (width_reg > 64) ? 64 : width_reg;
    h = (height_reg < 2) ? 2 : (height_reg > 64) ? 64 : height_reg;
    i = (col > w - 1) ? w - 1 : col;
    j = (row > h - 1) ? h - 1 : row;
    xo = (ofs_reg == sla_pkg::OFS_XFACE) ? 32768 : 0;
    yo = (ofs_reg == sla_pkg::OFS_YFACE) ? 32768 : 0;
    x = (i <<< 16) + xo;
    y = (j <<< 16) + yo;
    u = sat32(bilerp(0, x, y, corner(x, 32768, w - 1), corner(y, 0, h - 2),
                     32768, 0, w, h, miss));
    v = sat32(bilerp(1, x, y, corner(x, 0, w - 2), corner(y, 32768, h - 1),
                     0, 32768, w, h, miss));
    xp = x - mul_step(ratio_reg, u);
    yp = y - mul_step(ratio_reg, v);
    if (xp < 0) xp = 0;
    if (xp > ((w - 1) <<< 16)) xp = (w - 1) <<< 16;
    if (yp < 0) yp = 0;
    if (yp > ((h - 1) <<< 16)) yp = (h - 1) <<< 16;
    res = sat32(bilerp(2, xp, yp, corner(xp, xo, w - 1), corner(yp, yo, h - 1),
                       xo, yo, w, h, miss));
    return miss;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [31:0] pick_value(bit is_vel);
    int sel;
    sel = $urandom_range(15);
    if (sel == 0) return 32'h7FFF_FFFF;
    if (sel == 1) return 32'h8000_0000;
    if (sel < 5) return $urandom;
    if (is_vel) return 32'($signed($urandom_range(6 * 65536)) - 3 * 65536);
    return 32'($signed($urandom_range(200 * 65536)) - 100 * 65536);
  endfunction

  task automatic send_item(logic [1:0] mode, logic [5:0] col, logic [5:0] row,
                           logic [31:0] sample);
    advect_t e;
    longint  r;
    int      m;
    while (!quiet && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0, sample, row, col};
    // ready is stable between edges; look at it mid-cycle
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    if (mode == sla_pkg::MODE_COMPUTE) begin
      m = advect_cell(col, row, r);
      e.col = col;
      e.row = row;
      e.value = 32'(r);
      pending_q.push_back(e);
    end else begin
      grid_val[mode][int'(row) * 64 + int'(col)] = longint'($signed(sample));
      grid_set[mode][int'(row) * 64 + int'(col)] = 1'b1;
    end
  endtask

  task automatic compute_cell(logic [5:0] col, logic [5:0] row);
    longint r;
    int     m;
    m = advect_cell(col, row, r);
    while (m >= 0) begin
      send_item(2'(m / CELLS), 6'(m % 64), 6'((m % CELLS) / 64), pick_value(m < 2 * CELLS));
      m = advect_cell(col, row, r);
    end
    send_item(sla_pkg::MODE_COMPUTE, col, row, $urandom);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      sla_pkg::REG_GRID_WIDTH:  width_reg  = val[6:0];
      sla_pkg::REG_GRID_HEIGHT: height_reg = val[6:0];
      sla_pkg::REG_STEP_RATIO:  ratio_reg  = val;
      default:                  ofs_reg    = val[1:0];
    endcase
  endtask

  task automatic configure(logic [6:0] w, logic [6:0] h, logic [31:0] s, logic [1:0] o);
    drain();
    write_reg(sla_pkg::REG_GRID_WIDTH,  ($urandom & 32'hFFFF_FF80) | w);
    write_reg(sla_pkg::REG_GRID_HEIGHT, ($urandom & 32'hFFFF_FF80) | h);
    write_reg(sla_pkg::REG_STEP_RATIO,  s);
    write_reg(sla_pkg::REG_FIELD_OFS,   ($urandom & 32'hFFFF_FFFC) | o);
  endtask

  function automatic logic [6:0] pick_size();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return 7'd2;
    if (sel == 1) return 7'd64;
    if (sel == 2) return 7'($urandom_range(1));
    if (sel == 3) return 7'($urandom_range(127, 65));
    return 7'($urandom_range(16, 2));
  endfunction

  function automatic logic [31:0] pick_ratio();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 32'd0;
    if (sel == 1) return 32'hFFFF_FFFF;
    if (sel == 2) return $urandom;
    return 32'($urandom_range(32'h0400_0000));
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    configure(7'd2, 7'd2, sla_pkg::STEP_RATIO_RST, sla_pkg::OFS_CENTER);
    send_item(sla_pkg::MODE_LOAD_X, 6'd0, 6'd0, 32'h7FFF_FFFF);
    send_item(sla_pkg::MODE_LOAD_X, 6'd1, 6'd0, 32'h8000_0000);
    send_item(sla_pkg::MODE_LOAD_Y, 6'd0, 6'd0, 32'h8000_0000);
    send_item(sla_pkg::MODE_LOAD_Y, 6'd1, 6'd1, 32'h7FFF_FFFF);
    send_item(sla_pkg::MODE_LOAD_F, 6'd0, 6'd0, 32'h7FFF_FFFF);
    send_item(sla_pkg::MODE_LOAD_F, 6'd1, 6'd0, 32'h8000_0000);
    send_item(sla_pkg::MODE_LOAD_F, 6'd0, 6'd1, 32'h8000_0000);
    send_item(sla_pkg::MODE_LOAD_F, 6'd1, 6'd1, 32'h7FFF_FFFF);
    compute_cell(6'd0, 6'd0);
    compute_cell(6'd1, 6'd1);
    compute_cell(6'd63, 6'd0);
    compute_cell(6'd0, 6'd63);
    for (int o = 1; o < 4; o++) begin
      configure(7'd2, 7'd2, 32'hFFFF_FFFF, 2'(o));
      compute_cell(6'd1, 6'd0);
      compute_cell(6'd63, 6'd63);
    end
    configure(7'd0, 7'd127, 32'd0, sla_pkg::OFS_CENTER);
    compute_cell(6'd1, 6'd40);
  endtask

  task automatic test_random_phase(int n);
    repeat (n) begin
      if ($urandom_range(9) < 7) begin
        compute_cell(6'($urandom), 6'($urandom));
      end else begin
        send_item(2'($urandom_range(2)), 6'($urandom), 6'($urandom),
                  pick_value($urandom_range(1)));
      end
    end
  endtask

  task automatic test_config_sweep();
    while (items_sent < N_ITEMS - 300) begin
      configure(pick_size(), pick_size(), pick_ratio(), 2'($urandom));
      test_random_phase(60);
    end
  endtask

  task automatic test_full_grid();
    configure(7'd64, 7'd64, pick_ratio(), sla_pkg::OFS_XFACE);
    test_random_phase(40);
  endtask

  task automatic test_no_stall();
    configure(7'd8, 7'd8, sla_pkg::STEP_RATIO_RST, sla_pkg::OFS_YFACE);
    quiet = 1'b1;
    test_random_phase(120);
    quiet = 1'b0;
  endtask

  task automatic test_sender_pause();
    configure(7'd6, 7'd5, pick_ratio(), sla_pkg::OFS_CENTER);
    repeat (3) begin
      test_random_phase(20);
      in_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clk);
    end
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    advect_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", out_tdata);
      end else begin
        e = pending_q.pop_front();
        if (out_tdata[5:0] !== e.col || out_tdata[11:6] !== e.row ||
            out_tdata[43:12] !== e.value || out_tdata[47:44] !== 4'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp col %0d row %0d value %h, got col %0d row %0d value %h",
                     e.col, e.row, e.value, out_tdata[5:0], out_tdata[11:6],
                     out_tdata[43:12]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    quiet       = 1'b0;
    mismatches  = 0;
    items_sent  = 0;
    idle_cycles = 0;
    width_reg   = sla_pkg::GRID_WIDTH_RST;
    height_reg  = sla_pkg::GRID_HEIGHT_RST;
    ratio_reg   = sla_pkg::STEP_RATIO_RST;
    ofs_reg     = sla_pkg::FIELD_OFS_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_no_stall();
    test_sender_pause();
    test_full_grid();
    test_config_sweep();
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
